// File: sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the timer table manager: opcodes, timer
// states and kinds, response codes and the controller/datapath link.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int DEF_TIMER_SLOTS = 16;
    localparam int MAX_EVENTS      = 16;
    localparam int EVW             = $clog2(MAX_EVENTS + 1);

    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    // Opcodes.
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    // Timer states.
    localparam logic [1:0] ST_INACTIVE  = 2'd0;
    localparam logic [1:0] ST_ACTIVE    = 2'd1;
    localparam logic [1:0] ST_EXPIRED   = 2'd2;
    localparam logic [1:0] ST_CANCELLED = 2'd3;

    // Timer kinds.
    localparam logic [1:0] KIND_HR  = 2'd2;
    localparam logic [1:0] KIND_BAD = 2'd3;

    // Response status codes.
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_BAD  = 2'd1;
    localparam logic [1:0] STS_BUSY = 2'd2;
    localparam logic [1:0] STS_FULL = 2'd3;

    // Result kinds.
    localparam logic RK_RESPONSE = 1'b0;
    localparam logic RK_EXPIRY   = 1'b1;

    typedef struct packed {
        logic accept;      // latch the input beat
        logic due_clr;     // clear the due mask and counters for a new tick
        logic scan_start;  // restart the slot scan
        logic scan_step;   // issue the next slot read
        logic sel_mode;    // 0: build due mask, 1: select the next due timer to fire
        logic exec;        // apply a command and load its response
        logic fire;        // load an expiry event for the selected slot
    } t_cmd;

    typedef struct packed {
        logic op_tick;
        logic scan_busy;
        logic none_due;
        logic last_ev;
        logic out_free;
    } t_sts;

endpackage

// File: sv/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// Controller state machine: sequences command execution and the tick scans
// and paces the result register.
// ----------------------------------------------------------------------------
module stt_ctrl
    import stt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_DUE    = 3'd2;
    localparam logic [2:0] S_SEL    = 3'd3;
    localparam logic [2:0] S_FIRE   = 3'd4;
    localparam logic [2:0] S_EXEC   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.op_tick) begin
                    o_cmd.due_clr    = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_DUE;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_DUE: begin
                o_cmd.scan_step = 1'b1;
                if (!i_sts.scan_busy) begin
                    if (i_sts.none_due) begin
                        n_state = S_EXEC;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SEL;
                    end
                end
            end
            S_SEL: begin
                o_cmd.sel_mode  = 1'b1;
                o_cmd.scan_step = 1'b1;
                if (!i_sts.scan_busy) begin
                    n_state = S_FIRE;
                end
            end
            S_FIRE: begin
                o_cmd.sel_mode = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.fire = 1'b1;
                    if (i_sts.last_ev) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SEL;
                    end
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/stt_datapath.sv
// ----------------------------------------------------------------------------
// stt_datapath
// Slot table, expiry memory, scan and selection registers and the result
// register of the timer table manager.
// ----------------------------------------------------------------------------
module stt_datapath
    import stt_pkg::*;
#(
    parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_handle,
    input  logic [1:0]  i_timer_kind,
    input  logic [31:0] i_delay_ms,
    input  logic [63:0] i_now_ns,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot_out,
    output logic [63:0] o_fire_time,
    output logic        o_last
);

    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);

    // Latched command.
    logic [2:0]  r_op;
    logic [3:0]  r_handle;
    logic [1:0]  r_kind;
    logic [31:0] r_delay;
    logic [63:0] r_now;
    logic [51:0] r_prod;

    // Slot table.
    logic [TIMER_SLOTS-1:0] r_used;
    logic [1:0]             r_state [TIMER_SLOTS];
    logic [1:0]             r_kind_tab [TIMER_SLOTS];
    logic [63:0]            r_exp_mem [TIMER_SLOTS];

    // Scan and selection.
    logic [CW-1:0]          r_idx;
    logic [IW-1:0]          r_rd_idx;
    logic                   r_rd_vld;
    logic [63:0]            r_rd_exp;
    logic [TIMER_SLOTS-1:0] r_due;
    logic [CW-1:0]          r_due_cnt;
    logic [EVW-1:0]         r_ev_cnt;
    logic                   r_best_vld;
    logic [IW-1:0]          r_best_idx;
    logic                   r_best_grp;
    logic [63:0]            r_best_exp;

    // Result register.
    logic        r_out_valid;
    logic        r_rk;
    logic [1:0]  r_sts;
    logic [3:0]  r_slot;
    logic [63:0] r_ft;
    logic        r_last;

    logic [51:0]    w_prod;
    logic           w_free_any;
    logic [IW-1:0]  w_free_idx;
    logic [IW-1:0]  w_h_idx;
    logic           w_h_ok;
    logic [1:0]     w_h_state;
    logic [1:0]     w_rsp_st;
    logic [3:0]     w_rsp_slot;
    logic           w_wr_create;
    logic           w_wr_start;
    logic           w_wr_stop;
    logic           w_wr_del;
    logic           w_step;
    logic           w_out_free;
    logic           w_rd_grp;
    logic           w_due_hit;
    logic           w_better;
    logic [EVW-1:0] w_lim;

    assign w_prod = 52'(r_delay) * 52'(NS_PER_MS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_opcode;
            r_handle <= i_handle;
            r_kind   <= i_timer_kind;
            r_delay  <= i_delay_ms;
            r_now    <= i_now_ns;
        end
        r_prod <= w_prod;
    end

    // Lowest free slot.
    always_comb begin
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_any = 1'b1;
                w_free_idx = IW'(i);
            end
        end
    end

    assign w_h_idx   = IW'(r_handle);
    assign w_h_ok    = (32'(r_handle) < TIMER_SLOTS) && r_used[w_h_idx];
    assign w_h_state = r_state[w_h_idx];

    always_comb begin
        w_rsp_st    = STS_BAD;
        w_rsp_slot  = '0;
        w_wr_create = 1'b0;
        w_wr_start  = 1'b0;
        w_wr_stop   = 1'b0;
        w_wr_del    = 1'b0;
        unique case (r_op)
            OP_CREATE: begin
                if (r_kind == KIND_BAD) begin
                    w_rsp_st = STS_BAD;
                end else if (!w_free_any) begin
                    w_rsp_st = STS_FULL;
                end else begin
                    w_rsp_st    = STS_OK;
                    w_rsp_slot  = 4'(w_free_idx);
                    w_wr_create = 1'b1;
                end
            end
            OP_START: begin
                w_rsp_slot = r_handle;
                if (!w_h_ok) begin
                    w_rsp_st = STS_BAD;
                end else if (w_h_state == ST_ACTIVE) begin
                    w_rsp_st = STS_BUSY;
                end else begin
                    w_rsp_st   = STS_OK;
                    w_wr_start = 1'b1;
                end
            end
            OP_STOP: begin
                w_rsp_slot = r_handle;
                if (!w_h_ok || w_h_state != ST_ACTIVE) begin
                    w_rsp_st = STS_BAD;
                end else begin
                    w_rsp_st  = STS_OK;
                    w_wr_stop = 1'b1;
                end
            end
            OP_DELETE: begin
                w_rsp_slot = r_handle;
                if (!w_h_ok) begin
                    w_rsp_st = STS_BAD;
                end else begin
                    w_rsp_st = STS_OK;
                    w_wr_del = 1'b1;
                end
            end
            OP_TICK: begin
                w_rsp_st = STS_OK;
            end
            default: begin
                w_rsp_st = STS_BAD;
            end
        endcase
    end

    // Slot table updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.exec) begin
            if (w_wr_create) begin
                r_used[w_free_idx] <= 1'b1;
            end
            if (w_wr_del) begin
                r_used[w_h_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (w_wr_create) begin
                r_state[w_free_idx]    <= ST_INACTIVE;
                r_kind_tab[w_free_idx] <= r_kind;
            end
            if (w_wr_start) begin
                r_state[w_h_idx] <= ST_ACTIVE;
            end
            if (w_wr_stop) begin
                r_state[w_h_idx] <= ST_CANCELLED;
            end
            if (w_wr_del) begin
                r_state[w_h_idx] <= ST_INACTIVE;
            end
        end else if (i_cmd.fire) begin
            r_state[r_best_idx] <= ST_EXPIRED;
        end
    end

    assign w_step = i_cmd.scan_step && !i_cmd.scan_start && (r_idx != CW'(TIMER_SLOTS));

    // Expiry memory: one write port for create, one registered read for scans.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr_create) begin
            r_exp_mem[w_free_idx] <= r_now + {12'b0, r_prod};
        end
        if (w_step) begin
            r_rd_exp <= r_exp_mem[r_idx[IW-1:0]];
            r_rd_idx <= r_idx[IW-1:0];
        end
    end

    assign w_rd_grp  = (r_kind_tab[r_rd_idx] == KIND_HR);
    assign w_due_hit = r_used[r_rd_idx] && (r_state[r_rd_idx] == ST_ACTIVE)
                       && (r_rd_exp <= r_now);
    // Slots arrive in ascending order, so a strict compare keeps ties on the
    // lower slot.
    assign w_better  = !r_best_vld || (!w_rd_grp && r_best_grp)
                       || ((w_rd_grp == r_best_grp) && (r_rd_exp < r_best_exp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_due_cnt  <= '0;
            r_ev_cnt   <= '0;
        end else begin
            if (i_cmd.scan_start) begin
                r_idx      <= '0;
                r_rd_vld   <= 1'b0;
                r_best_vld <= 1'b0;
            end else begin
                r_rd_vld <= w_step;
                if (w_step) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            if (i_cmd.due_clr) begin
                r_due_cnt <= '0;
                r_ev_cnt  <= '0;
            end else if (r_rd_vld && !i_cmd.sel_mode && w_due_hit) begin
                r_due_cnt <= r_due_cnt + CW'(1);
            end
            if (i_cmd.fire) begin
                r_ev_cnt <= r_ev_cnt + EVW'(1);
            end
            if (!i_cmd.scan_start && r_rd_vld && i_cmd.sel_mode && r_due[r_rd_idx]
                && w_better) begin
                r_best_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.due_clr) begin
            r_due <= '0;
        end else if (i_cmd.fire) begin
            r_due[r_best_idx] <= 1'b0;
        end else if (r_rd_vld && !i_cmd.sel_mode) begin
            r_due[r_rd_idx] <= w_due_hit;
        end
        if (r_rd_vld && i_cmd.sel_mode && r_due[r_rd_idx] && w_better) begin
            r_best_idx <= r_rd_idx;
            r_best_grp <= w_rd_grp;
            r_best_exp <= r_rd_exp;
        end
    end

    assign w_lim = (32'(r_due_cnt) >= MAX_EVENTS) ? EVW'(MAX_EVENTS) : EVW'(r_due_cnt);

    // Result register.
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rk   <= RK_RESPONSE;
            r_sts  <= w_rsp_st;
            r_slot <= w_rsp_slot;
            r_ft   <= '0;
            r_last <= 1'b1;
        end else if (i_cmd.fire) begin
            r_rk   <= RK_EXPIRY;
            r_sts  <= STS_OK;
            r_slot <= 4'(r_best_idx);
            r_ft   <= r_now;
            r_last <= o_sts.last_ev;
        end
    end

    assign o_sts.op_tick   = (r_op == OP_TICK);
    assign o_sts.scan_busy = (r_idx != CW'(TIMER_SLOTS)) || r_rd_vld;
    assign o_sts.none_due  = (r_due_cnt == '0);
    assign o_sts.last_ev   = ((r_ev_cnt + EVW'(1)) == w_lim);
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_rk;
    assign o_status      = r_sts;
    assign o_slot_out    = r_slot;
    assign o_fire_time   = r_ft;
    assign o_last        = r_last;

endmodule

// File: sv/software_timer_table_manager.sv
// ----------------------------------------------------------------------------
// Command response: registered after the decode and execute states once the result
// register is free; one item at a time. Tick: decode, a due-marking pass over all
// slots, then a selection pass per expiry (at most 16), or one response if none due.
// A new item is taken once the last result of the previous one is registered.
// Reset clears slot allocation and all control; there is no clearing pass.
// ----------------------------------------------------------------------------
// software_timer_table_manager
// Timer slot table with create/start/stop/delete commands and ordered expiry
// events on each tick.
// ----------------------------------------------------------------------------
module software_timer_table_manager
    import stt_pkg::*;
#(
    parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_handle,
    input  logic [1:0]  i_timer_kind,
    input  logic [31:0] i_delay_ms,
    input  logic [63:0] i_now_ns,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot_out,
    output logic [63:0] o_fire_time,
    output logic        o_last
);

    t_cmd w_cmd;
    t_sts w_sts;

    stt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    stt_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_opcode      (i_opcode),
        .i_handle      (i_handle),
        .i_timer_kind  (i_timer_kind),
        .i_delay_ms    (i_delay_ms),
        .i_now_ns      (i_now_ns),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_status      (o_status),
        .o_slot_out    (o_slot_out),
        .o_fire_time   (o_fire_time),
        .o_last        (o_last)
    );

endmodule

// File: tb/software_timer_table_manager_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_table_manager_test
// Drives create, start, stop, delete and tick commands into the timer table
// and checks every response and expiry event against a behavioral table kept
// in the testbench, with random idling on both the command and result sides.
// ----------------------------------------------------------------------------
module software_timer_table_manager_test;
    import stt_pkg::*;

    localparam int SLOTS = DEF_TIMER_SLOTS;

    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam logic [1:0] KIND_ONESHOT  = 2'd0;
    localparam logic [1:0] KIND_PERIODIC = 2'd1;

    typedef struct packed {
        logic        rk;
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [63:0] fire_time;
        logic        last;
    } t_timer_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_opcode;
    logic [3:0]  i_handle;
    logic [1:0]  i_timer_kind;
    logic [31:0] i_delay_ms;
    logic [63:0] i_now_ns;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_result_kind;
    logic [1:0]  o_status;
    logic [3:0]  o_slot_out;
    logic [63:0] o_fire_time;
    logic        o_last;

    // Shadow copy of the timer table.
    logic        slot_live  [SLOTS];
    logic [1:0]  slot_class [SLOTS];
    logic [1:0]  slot_phase [SLOTS];
    logic [63:0] slot_due_ns[SLOTS];

    t_timer_result pending_results[$];
    int            mismatch_count = 0;
    bit            idle_en = 1'b1;

    software_timer_table_manager DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_handle     (i_handle),
        .i_timer_kind (i_timer_kind),
        .i_delay_ms   (i_delay_ms),
        .i_now_ns     (i_now_ns),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result_kind(o_result_kind),
        .o_status     (o_status),
        .o_slot_out   (o_slot_out),
        .o_fire_time  (o_fire_time),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t ns: %s is %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void push_result(input logic rk, input logic [1:0] status,
                                        input logic [3:0] slot,
                                        input logic [63:0] fire_time,
                                        input logic last);
        t_timer_result r;
        r.rk        = rk;
        r.status    = status;
        r.slot      = slot;
        r.fire_time = fire_time;
        r.last      = last;
        pending_results.push_back(r);
    endfunction

    function automatic void push_response(input logic [1:0] status,
                                          input logic [3:0] slot);
        push_result(RK_RESPONSE, status, slot, 64'd0, 1'b1);
    endfunction

    // Periodic and oneshot timers go ahead of high-resolution ones, then the
    // earlier expiry, then the lower slot.
    function automatic bit fires_first(input int a, input int b);
        bit hr_a;
        bit hr_b;
        hr_a = (slot_class[a] == KIND_HR);
        hr_b = (slot_class[b] == KIND_HR);
        if (hr_a != hr_b) return !hr_a;
        if (slot_due_ns[a] != slot_due_ns[b]) return slot_due_ns[a] < slot_due_ns[b];
        return a < b;
    endfunction

    task automatic predict_tick(input logic [63:0] now);
        int fired[MAX_EVENTS];
        int n;
        int best;
        n = 0;
        while (n < MAX_EVENTS) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_live[i] && slot_phase[i] == ST_ACTIVE && slot_due_ns[i] <= now) begin
                    if (best < 0 || fires_first(i, best)) best = i;
                end
            end
            if (best < 0) break;
            slot_phase[best] = ST_EXPIRED;
            fired[n] = best;
            n++;
        end
        if (n == 0) begin
            push_response(STS_OK, 4'd0);
        end else begin
            for (int k = 0; k < n; k++) begin
                push_result(RK_EXPIRY, STS_OK, 4'(fired[k]), now, k == n - 1);
            end
        end
    endtask

    task automatic predict_timer_op(input logic [2:0] op, input logic [3:0] hdl,
                                    input logic [1:0] kind, input logic [31:0] dly,
                                    input logic [63:0] now);
        int free_slot;
        free_slot = -1;
        case (op)
            OP_CREATE: begin
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!slot_live[i]) free_slot = i;
                end
                if (kind == KIND_BAD) begin
                    push_response(STS_BAD, 4'd0);
                end else if (free_slot < 0) begin
                    push_response(STS_FULL, 4'd0);
                end else begin
                    slot_live[free_slot]   = 1'b1;
                    slot_class[free_slot]  = kind;
                    slot_phase[free_slot]  = ST_INACTIVE;
                    slot_due_ns[free_slot] = now + 64'(dly) * 64'(NS_PER_MS);
                    push_response(STS_OK, 4'(free_slot));
                end
            end
            OP_START: begin
                if (!slot_live[hdl]) begin
                    push_response(STS_BAD, hdl);
                end else if (slot_phase[hdl] == ST_ACTIVE) begin
                    push_response(STS_BUSY, hdl);
                end else begin
                    slot_phase[hdl] = ST_ACTIVE;
                    push_response(STS_OK, hdl);
                end
            end
            OP_STOP: begin
                if (!slot_live[hdl] || slot_phase[hdl] != ST_ACTIVE) begin
                    push_response(STS_BAD, hdl);
                end else begin
                    slot_phase[hdl] = ST_CANCELLED;
                    push_response(STS_OK, hdl);
                end
            end
            OP_DELETE: begin
                if (!slot_live[hdl]) begin
                    push_response(STS_BAD, hdl);
                end else begin
                    slot_live[hdl]  = 1'b0;
                    slot_phase[hdl] = ST_INACTIVE;
                    push_response(STS_OK, hdl);
                end
            end
            OP_TICK: predict_tick(now);
            default: push_response(STS_BAD, 4'd0);
        endcase
    endtask

    // Sends one command beat; entered and left at a falling edge.
    task automatic drive_command(input logic [2:0] op, input logic [3:0] hdl,
                                 input logic [1:0] kind, input logic [31:0] dly,
                                 input logic [63:0] now);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        predict_timer_op(op, hdl, kind, dly, now);
        i_in_valid   = 1'b1;
        i_opcode     = op;
        i_handle     = hdl;
        i_timer_kind = kind;
        i_delay_ms   = dly;
        i_now_ns     = now;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) n += int'(slot_live[i]);
        return n;
    endfunction

    // Mostly a handle that exists, now and then any handle.
    function automatic logic [3:0] pick_handle();
        int live[$];
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) live.push_back(i);
        end
        if (live.size() == 0 || $urandom_range(0, 99) < 15) return 4'($urandom);
        return 4'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    task automatic random_command(inout logic [63:0] clock_ns);
        int          pick;
        int          del_weight;
        logic [1:0]  kind;
        logic [31:0] dly;
        pick       = $urandom_range(0, 99);
        del_weight = (live_count() > 12) ? 20 : 8;
        if (pick < 8) begin
            drive_command(3'($urandom), 4'($urandom), 2'($urandom), $urandom,
                          {$urandom, $urandom});
        end else if (pick < 30) begin
            kind = ($urandom_range(0, 9) == 0) ? KIND_BAD : 2'($urandom_range(0, 2));
            dly  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
            drive_command(OP_CREATE, 4'($urandom), kind, dly, clock_ns);
        end else if (pick < 52) begin
            drive_command(OP_START, pick_handle(), 2'($urandom), $urandom, {$urandom, $urandom});
        end else if (pick < 62) begin
            drive_command(OP_STOP, pick_handle(), 2'($urandom), $urandom, {$urandom, $urandom});
        end else if (pick < 62 + del_weight) begin
            drive_command(OP_DELETE, pick_handle(), 2'($urandom), $urandom,
                          {$urandom, $urandom});
        end else begin
            clock_ns = clock_ns + 64'($urandom_range(0, 3)) * 64'(NS_PER_MS)
                     + 64'($urandom_range(0, 1000));
            drive_command(OP_TICK, 4'($urandom), 2'($urandom), $urandom, clock_ns);
        end
    endtask

    task automatic test_directed_basics();
        drive_command(OP_TICK, 4'd0, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_CREATE, 4'd0, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_CREATE, 4'hF, KIND_PERIODIC, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        drive_command(OP_CREATE, 4'd0, KIND_HR, 32'd1, 64'd5);
        drive_command(OP_CREATE, 4'd0, KIND_BAD, 32'd7, 64'd0);
        drive_command(OP_START, 4'd0, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_START, 4'd0, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_STOP, 4'd1, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_START, 4'd1, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_START, 4'd2, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_STOP, 4'd1, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_START, 4'd1, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_START, 4'hF, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_STOP, 4'hF, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_DELETE, 4'hF, KIND_ONESHOT, 32'd0, 64'd0);
        // The periodic timer's expiry wrapped, so all three are due at the top of time.
        drive_command(OP_TICK, 4'd0, KIND_ONESHOT, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        drive_command(OP_STOP, 4'd0, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_START, 4'd0, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_TICK, 4'd0, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_DELETE, 4'd0, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_DELETE, 4'd1, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_DELETE, 4'd2, KIND_ONESHOT, 32'd0, 64'd0);
        drive_command(OP_RSVD5, 4'($urandom), 2'($urandom), $urandom, {$urandom, $urandom});
        drive_command(OP_RSVD6, 4'($urandom), 2'($urandom), $urandom, {$urandom, $urandom});
        drive_command(OP_RSVD7, 4'($urandom), 2'($urandom), $urandom, {$urandom, $urandom});
    endtask

    // Fills every slot, overflows the table, then fires all sixteen in one tick.
    task automatic test_full_table();
        logic [63:0] base_ns;
        base_ns = {$urandom, $urandom} >> 1;
        for (int i = 0; i < SLOTS; i++) begin
            drive_command(OP_CREATE, 4'($urandom), 2'(i % 3), 32'($urandom_range(0, 1)),
                          base_ns);
        end
        drive_command(OP_CREATE, 4'($urandom), KIND_ONESHOT, 32'd0, base_ns);
        for (int i = 0; i < SLOTS; i++) begin
            drive_command(OP_START, 4'(i), 2'($urandom), $urandom, 64'd0);
        end
        drive_command(OP_TICK, 4'd0, KIND_ONESHOT, 32'd0, base_ns + 64'd2_000_000);
        for (int i = 0; i < SLOTS; i += 2) begin
            drive_command(OP_DELETE, 4'(i), 2'($urandom), $urandom, 64'd0);
        end
    endtask

    task automatic test_random_traffic(input int count);
        logic [63:0] clock_ns;
        clock_ns = {$urandom, $urandom};
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) wait_drained();
            random_command(clock_ns);
        end
    endtask

    task automatic test_back_to_back(input int count);
        logic [63:0] clock_ns;
        idle_en  = 1'b0;
        // Start just short of the top so that expiries wrap around zero.
        clock_ns = 64'hFFFF_FFFF_FFF0_0000;
        for (int n = 0; n < count; n++) random_command(clock_ns);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_TICK;
        i_handle     = 4'd0;
        i_timer_kind = KIND_ONESHOT;
        i_delay_ms   = 32'd0;
        i_now_ns     = 64'd0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_live[i]  = 1'b0;
            slot_phase[i] = ST_INACTIVE;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_basics();
        test_full_table();
        test_random_traffic(130);
        test_back_to_back(60);

        wait_drained();
        repeat (400) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results still outstanding", 64'd0,
                            64'(pending_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("software_timer_table_manager: match");
        end else begin
            $display("software_timer_table_manager: mismatch");
        end
        $finish;
    end

    // Result side back-pressure.
    initial begin
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_out_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat, slot", 64'(o_slot_out), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_result_kind !== want.rk)
                    report_mismatch("result_kind", 64'(o_result_kind), 64'(want.rk));
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_slot_out !== want.slot)
                    report_mismatch("slot_out", 64'(o_slot_out), 64'(want.slot));
                if (o_fire_time !== want.fire_time)
                    report_mismatch("fire_time", o_fire_time, want.fire_time);
                if (o_last !== want.last)
                    report_mismatch("last", 64'(o_last), 64'(want.last));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("software_timer_table_manager: mismatch");
        $finish;
    end

endmodule
